FILE: design/clt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and constants for the command line tokeniser.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int unsigned MaxRes = 3;

    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChDash   = 8'h2D;
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChN      = 8'h6E;
    localparam logic [7:0] ChT      = 8'h74;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChSpace  = 8'h20;

    typedef enum logic [3:0] {
        M_IDLE           = 4'd0,
        M_DASH           = 4'd1,
        M_WORD           = 4'd2,
        M_QUOTE          = 4'd3,
        M_QUOTE_ESC      = 4'd4,
        M_FLAG           = 4'd5,
        M_AFTER_FLAG     = 4'd6,
        M_AFTER_FLAG_DSH = 4'd7,
        M_ARG            = 4'd8,
        M_ARG_QUOTE      = 4'd9,
        M_ARG_QUOTE_ESC  = 4'd10
    } scan_mode_t;

    typedef enum logic [2:0] {
        EV_KEY   = 3'd0,
        EV_PARAM = 3'd1,
        EV_FLAG  = 3'd2,
        EV_ARG   = 3'd3,
        EV_TEND  = 3'd4,
        EV_LEND  = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        KIND_KEY      = 2'd0,
        KIND_PARAM    = 2'd1,
        KIND_FLAG     = 2'd2,
        KIND_FLAG_ARG = 2'd3
    } kind_t;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_EOL  = 1'b1
    } cmd_t;

    typedef struct packed {
        event_t     ev;
        logic [7:0] data;
        kind_t      kind;
    } res_t;

    // Up to three results produced by one input word.
    typedef struct packed {
        logic [1:0]        cnt;
        res_t [MaxRes-1:0] res;
    } bundle_t;

    function automatic res_t mk_res(event_t ev, logic [7:0] data, kind_t kind);
        res_t r;
        r.ev   = ev;
        r.data = data;
        r.kind = kind;
        return r;
    endfunction

endpackage

FILE: design/clt_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_decode
// Combinational scan step: from the scan state and one input word it forms
// the next state and the bundle of results the word causes.
// ----------------------------------------------------------------------------
module clt_decode import clt_pkg::*; (
    input  scan_mode_t mode,
    input  logic       seen,
    input  logic       cmd,
    input  logic [7:0] text_byte,
    output scan_mode_t mode_next,
    output logic       seen_next,
    output bundle_t    bundle
);

    logic       ws;
    logic       esc_two;
    logic [7:0] esc_byte;
    res_t       r0, r1, r2;
    logic [1:0] cnt;
    res_t       nul;

    assign ws  = ((text_byte >= ChTab) && (text_byte <= ChCr)) || (text_byte == ChSpace);
    assign nul = mk_res(EV_KEY, 8'h00, KIND_KEY);

    // An unknown escape keeps the backslash in front of the byte.
    always_comb begin
        esc_two  = 1'b0;
        esc_byte = text_byte;
        if (text_byte == ChN) begin
            esc_byte = ChLf;
        end else if (text_byte == ChT) begin
            esc_byte = ChTab;
        end else if ((text_byte == ChBslash) || (text_byte == ChQuote)) begin
            esc_byte = text_byte;
        end else begin
            esc_two  = 1'b1;
            esc_byte = ChBslash;
        end
    end

    always_comb begin
        mode_next = mode;
        seen_next = seen;
        cnt       = 2'd0;
        r0        = nul;
        r1        = nul;
        r2        = nul;
        if (cmd == CMD_EOL) begin
            mode_next = M_IDLE;
            seen_next = 1'b0;
            unique case (mode)
                M_DASH: begin
                    r0  = mk_res(EV_KEY, ChDash, KIND_KEY);
                    r1  = mk_res(EV_TEND, 8'h00, KIND_KEY);
                    r2  = mk_res(EV_LEND, 8'h00, KIND_KEY);
                    cnt = 2'd3;
                end
                M_WORD: begin
                    r0  = mk_res(EV_TEND, 8'h00, KIND_KEY);
                    r1  = mk_res(EV_LEND, 8'h00, KIND_KEY);
                    cnt = 2'd2;
                end
                M_QUOTE, M_QUOTE_ESC: begin
                    r0  = mk_res(EV_TEND, 8'h00, KIND_PARAM);
                    r1  = mk_res(EV_LEND, 8'h00, KIND_KEY);
                    cnt = 2'd2;
                end
                M_FLAG, M_AFTER_FLAG: begin
                    r0  = mk_res(EV_TEND, 8'h00, KIND_FLAG);
                    r1  = mk_res(EV_LEND, 8'h00, KIND_KEY);
                    cnt = 2'd2;
                end
                M_AFTER_FLAG_DSH: begin
                    r0  = mk_res(EV_ARG, ChDash, KIND_KEY);
                    r1  = mk_res(EV_TEND, 8'h00, KIND_FLAG_ARG);
                    r2  = mk_res(EV_LEND, 8'h00, KIND_KEY);
                    cnt = 2'd3;
                end
                M_ARG, M_ARG_QUOTE, M_ARG_QUOTE_ESC: begin
                    r0  = mk_res(EV_TEND, 8'h00, KIND_FLAG_ARG);
                    r1  = mk_res(EV_LEND, 8'h00, KIND_KEY);
                    cnt = 2'd2;
                end
                default: begin
                    r0  = mk_res(EV_LEND, 8'h00, KIND_KEY);
                    cnt = 2'd1;
                end
            endcase
        end else begin
            unique case (mode)
                M_DASH: begin
                    // A second dash turns the held dash into a flag and shows nothing.
                    if (text_byte == ChDash) begin
                        mode_next = M_FLAG;
                    end else if (ws) begin
                        r0        = mk_res(EV_KEY, ChDash, KIND_KEY);
                        r1        = mk_res(EV_TEND, 8'h00, KIND_KEY);
                        cnt       = 2'd2;
                        mode_next = M_IDLE;
                    end else begin
                        r0        = mk_res(EV_KEY, ChDash, KIND_KEY);
                        r1        = mk_res(EV_KEY, text_byte, KIND_KEY);
                        cnt       = 2'd2;
                        mode_next = M_WORD;
                    end
                end
                M_WORD: begin
                    if (ws) begin
                        r0        = mk_res(EV_TEND, 8'h00, KIND_KEY);
                        mode_next = M_IDLE;
                    end else begin
                        r0 = mk_res(EV_KEY, text_byte, KIND_KEY);
                    end
                    cnt = 2'd1;
                end
                M_QUOTE: begin
                    if (text_byte == ChQuote) begin
                        r0        = mk_res(EV_TEND, 8'h00, KIND_PARAM);
                        cnt       = 2'd1;
                        mode_next = M_IDLE;
                    end else if (text_byte == ChBslash) begin
                        mode_next = M_QUOTE_ESC;
                    end else begin
                        r0  = mk_res(EV_PARAM, text_byte, KIND_KEY);
                        cnt = 2'd1;
                    end
                end
                M_QUOTE_ESC: begin
                    r0        = mk_res(EV_PARAM, esc_byte, KIND_KEY);
                    r1        = mk_res(EV_PARAM, text_byte, KIND_KEY);
                    cnt       = esc_two ? 2'd2 : 2'd1;
                    mode_next = M_QUOTE;
                end
                M_FLAG: begin
                    if (ws) begin
                        mode_next = M_AFTER_FLAG;
                    end else begin
                        r0  = mk_res(EV_FLAG, text_byte, KIND_KEY);
                        cnt = 2'd1;
                    end
                end
                M_AFTER_FLAG: begin
                    if (ws) begin
                        mode_next = M_AFTER_FLAG;
                    end else if (text_byte == ChDash) begin
                        mode_next = M_AFTER_FLAG_DSH;
                    end else if (text_byte == ChQuote) begin
                        mode_next = M_ARG_QUOTE;
                    end else begin
                        r0        = mk_res(EV_ARG, text_byte, KIND_KEY);
                        cnt       = 2'd1;
                        mode_next = M_ARG;
                    end
                end
                M_AFTER_FLAG_DSH: begin
                    if (text_byte == ChDash) begin
                        r0        = mk_res(EV_TEND, 8'h00, KIND_FLAG);
                        cnt       = 2'd1;
                        mode_next = M_FLAG;
                    end else if (ws) begin
                        r0        = mk_res(EV_ARG, ChDash, KIND_KEY);
                        r1        = mk_res(EV_TEND, 8'h00, KIND_FLAG_ARG);
                        cnt       = 2'd2;
                        mode_next = M_IDLE;
                    end else begin
                        r0        = mk_res(EV_ARG, ChDash, KIND_KEY);
                        r1        = mk_res(EV_ARG, text_byte, KIND_KEY);
                        cnt       = 2'd2;
                        mode_next = M_ARG;
                    end
                end
                M_ARG: begin
                    if (ws) begin
                        r0        = mk_res(EV_TEND, 8'h00, KIND_FLAG_ARG);
                        mode_next = M_IDLE;
                    end else begin
                        r0 = mk_res(EV_ARG, text_byte, KIND_KEY);
                    end
                    cnt = 2'd1;
                end
                M_ARG_QUOTE: begin
                    if (text_byte == ChQuote) begin
                        r0        = mk_res(EV_TEND, 8'h00, KIND_FLAG_ARG);
                        cnt       = 2'd1;
                        mode_next = M_IDLE;
                    end else if (text_byte == ChBslash) begin
                        mode_next = M_ARG_QUOTE_ESC;
                    end else begin
                        r0  = mk_res(EV_ARG, text_byte, KIND_KEY);
                        cnt = 2'd1;
                    end
                end
                M_ARG_QUOTE_ESC: begin
                    r0        = mk_res(EV_ARG, esc_byte, KIND_KEY);
                    r1        = mk_res(EV_ARG, text_byte, KIND_KEY);
                    cnt       = esc_two ? 2'd2 : 2'd1;
                    mode_next = M_ARG_QUOTE;
                end
                default: begin
                    mode_next = M_IDLE;
                    if (!ws) begin
                        seen_next = 1'b1;
                        // A slash opening the line is a keyword on its own.
                        if ((text_byte == ChSlash) && !seen) begin
                            r0  = mk_res(EV_KEY, ChSlash, KIND_KEY);
                            r1  = mk_res(EV_TEND, 8'h00, KIND_KEY);
                            cnt = 2'd2;
                        end else if (text_byte == ChDash) begin
                            mode_next = M_DASH;
                        end else if (text_byte == ChQuote) begin
                            mode_next = M_QUOTE;
                        end else begin
                            r0        = mk_res(EV_KEY, text_byte, KIND_KEY);
                            cnt       = 2'd1;
                            mode_next = M_WORD;
                        end
                    end
                end
            endcase
        end
    end

    assign bundle.cnt    = cnt;
    assign bundle.res[0] = r0;
    assign bundle.res[1] = r1;
    assign bundle.res[2] = r2;

endmodule

FILE: design/clt_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_emit
// Result register: holds the bundle of one input word and hands its results
// out one word per cycle while m_ready is high, flagging the last of the run.
// ----------------------------------------------------------------------------
module clt_emit import clt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  bundle_t    bundle,
    output logic       free,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_res,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_token_kind,
    output logic       m_last_of_run
);

    logic              busy_reg, busy_next;
    logic [1:0]        pos_reg, pos_next;
    logic [1:0]        cnt_reg, cnt_next;
    res_t [MaxRes-1:0] res_reg, res_next;
    logic              last;
    res_t              cur;

    assign last = (pos_reg == (cnt_reg - 2'd1));
    assign free = !busy_reg || (m_ready && last);
    assign cur  = res_reg[pos_reg];

    always_comb begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        cnt_next  = cnt_reg;
        res_next  = res_reg;
        if (busy_reg && m_ready) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                pos_next = pos_reg + 2'd1;
            end
        end
        // A word with no results leaves the register empty.
        if (load) begin
            busy_next = (bundle.cnt != 2'd0);
            pos_next  = 2'd0;
            cnt_next  = bundle.cnt;
            res_next  = bundle.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= 2'd0;
            cnt_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
            cnt_reg  <= cnt_next;
        end
        res_reg <= res_next;
    end

    assign m_valid       = busy_reg;
    assign m_event_res   = cur.ev;
    assign m_out_byte    = cur.data;
    assign m_token_kind  = cur.kind;
    assign m_last_of_run = last;

    a_busy_has_results: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg != 2'd0) && (pos_reg < cnt_reg))
        else $error("result register busy with an empty or overrun run");

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("new bundle loaded over results not yet delivered");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> m_valid && (pos_reg == $past(pos_reg) + 2'd1))
        else $error("run of results broken before its last word");

    a_load_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && (bundle.cnt != 2'd0)) |=> m_valid && (pos_reg == 2'd0))
        else $error("loaded bundle did not start at its first result");

endmodule

FILE: design/command_line_tokenizer.sv
`timescale 1ns / 1ps
// The first result of a byte is registered and appears in the cycle after it is accepted.
// Throughput: one input word per cycle while the receiver is ready and each
// causes at most one result; a word causing several results holds the input
// while the result register drains, one result word per cycle while m_ready is high.
// Reset: synchronous, active low; the scan returns to idle at each line end.
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Streaming command line tokeniser: scan state register, one-step decoder and
// a result register that serialises up to three results per input word.
// ----------------------------------------------------------------------------
module command_line_tokenizer import clt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic [7:0] s_text_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_res,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_token_kind,
    output logic       m_last_of_run
);

    scan_mode_t mode_reg, mode_next;
    logic       seen_reg, seen_next;
    bundle_t    bundle;
    logic       free;
    logic       accept;

    assign s_ready = free;
    assign accept  = s_valid && free;

    clt_decode u_decode (
        .mode      (mode_reg),
        .seen      (seen_reg),
        .cmd       (s_cmd),
        .text_byte (s_text_byte),
        .mode_next (mode_next),
        .seen_next (seen_next),
        .bundle    (bundle)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            seen_reg <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            seen_reg <= seen_next;
        end
    end

    clt_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (accept),
        .bundle        (bundle),
        .free          (free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_res   (m_event_res),
        .m_out_byte    (m_out_byte),
        .m_token_kind  (m_token_kind),
        .m_last_of_run (m_last_of_run)
    );

endmodule

FILE: test/tb_command_line_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_command_line_tokenizer
// Self-checking bench for the command line tokeniser. A scoreboard class keeps
// its own scan state, predicts the tagged result words for every accepted
// input word and compares them, in order, with what the block emits. Stimulus
// is a short directed run of awkward lines followed by random, mostly
// well-formed command lines under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_command_line_tokenizer;
    import clt_pkg::*;

    typedef struct {
        event_t     ev;
        logic [7:0] data;
        kind_t      kind;
        logic       last;
    } tok_event_t;

    class token_scoreboard;
        tok_event_t  awaited[$];
        tok_event_t  step_out[$];
        scan_mode_t  scan = M_IDLE;
        bit          line_has_token = 1'b0;
        int          mismatches = 0;
        int          results_checked = 0;

        static function bit blank(logic [7:0] b);
            return (b >= 8'd9 && b <= 8'd13) || b == ChSpace;
        endfunction

        function void add(event_t ev, logic [7:0] d, kind_t k);
            tok_event_t e;
            e.ev   = ev;
            e.data = d;
            e.kind = k;
            e.last = 1'b0;
            step_out = {step_out, e};
        endfunction

        // The byte following a backslash inside a quoted run.
        function void unescape(logic [7:0] b, event_t ev);
            case (b)
                ChN: add(ev, ChLf, KIND_KEY);
                ChT: add(ev, ChTab, KIND_KEY);
                ChBslash, ChQuote: add(ev, b, KIND_KEY);
                default: begin
                    add(ev, ChBslash, KIND_KEY);
                    add(ev, b, KIND_KEY);
                end
            endcase
        endfunction

        function void note_word(cmd_t cmd, logic [7:0] b);
            bit ws;
            ws = blank(b);
            step_out.delete();
            if (cmd == CMD_EOL) begin
                case (scan)
                    M_DASH: begin
                        add(EV_KEY, ChDash, KIND_KEY);
                        add(EV_TEND, 8'h00, KIND_KEY);
                    end
                    M_WORD: add(EV_TEND, 8'h00, KIND_KEY);
                    M_QUOTE, M_QUOTE_ESC: add(EV_TEND, 8'h00, KIND_PARAM);
                    M_FLAG, M_AFTER_FLAG: add(EV_TEND, 8'h00, KIND_FLAG);
                    M_AFTER_FLAG_DSH: begin
                        add(EV_ARG, ChDash, KIND_KEY);
                        add(EV_TEND, 8'h00, KIND_FLAG_ARG);
                    end
                    M_ARG, M_ARG_QUOTE, M_ARG_QUOTE_ESC: add(EV_TEND, 8'h00, KIND_FLAG_ARG);
                    default: ;
                endcase
                add(EV_LEND, 8'h00, KIND_KEY);
                scan = M_IDLE;
                line_has_token = 1'b0;
            end else begin
                case (scan)
                    M_DASH: begin
                        // A second dash turns the held dash into a flag with nothing emitted.
                        if (b == ChDash) begin
                            scan = M_FLAG;
                        end else if (ws) begin
                            add(EV_KEY, ChDash, KIND_KEY);
                            add(EV_TEND, 8'h00, KIND_KEY);
                            scan = M_IDLE;
                        end else begin
                            add(EV_KEY, ChDash, KIND_KEY);
                            add(EV_KEY, b, KIND_KEY);
                            scan = M_WORD;
                        end
                    end
                    M_WORD: begin
                        if (ws) begin
                            add(EV_TEND, 8'h00, KIND_KEY);
                            scan = M_IDLE;
                        end else begin
                            add(EV_KEY, b, KIND_KEY);
                        end
                    end
                    M_QUOTE: begin
                        if (b == ChQuote) begin
                            add(EV_TEND, 8'h00, KIND_PARAM);
                            scan = M_IDLE;
                        end else if (b == ChBslash) begin
                            scan = M_QUOTE_ESC;
                        end else begin
                            add(EV_PARAM, b, KIND_KEY);
                        end
                    end
                    M_QUOTE_ESC: begin
                        unescape(b, EV_PARAM);
                        scan = M_QUOTE;
                    end
                    M_FLAG: begin
                        if (ws) begin
                            scan = M_AFTER_FLAG;
                        end else begin
                            add(EV_FLAG, b, KIND_KEY);
                        end
                    end
                    M_AFTER_FLAG: begin
                        if (!ws) begin
                            if (b == ChDash) begin
                                scan = M_AFTER_FLAG_DSH;
                            end else if (b == ChQuote) begin
                                scan = M_ARG_QUOTE;
                            end else begin
                                add(EV_ARG, b, KIND_KEY);
                                scan = M_ARG;
                            end
                        end
                    end
                    M_AFTER_FLAG_DSH: begin
                        if (b == ChDash) begin
                            add(EV_TEND, 8'h00, KIND_FLAG);
                            scan = M_FLAG;
                        end else if (ws) begin
                            add(EV_ARG, ChDash, KIND_KEY);
                            add(EV_TEND, 8'h00, KIND_FLAG_ARG);
                            scan = M_IDLE;
                        end else begin
                            add(EV_ARG, ChDash, KIND_KEY);
                            add(EV_ARG, b, KIND_KEY);
                            scan = M_ARG;
                        end
                    end
                    M_ARG: begin
                        if (ws) begin
                            add(EV_TEND, 8'h00, KIND_FLAG_ARG);
                            scan = M_IDLE;
                        end else begin
                            add(EV_ARG, b, KIND_KEY);
                        end
                    end
                    M_ARG_QUOTE: begin
                        if (b == ChQuote) begin
                            add(EV_TEND, 8'h00, KIND_FLAG_ARG);
                            scan = M_IDLE;
                        end else if (b == ChBslash) begin
                            scan = M_ARG_QUOTE_ESC;
                        end else begin
                            add(EV_ARG, b, KIND_KEY);
                        end
                    end
                    M_ARG_QUOTE_ESC: begin
                        unescape(b, EV_ARG);
                        scan = M_ARG_QUOTE;
                    end
                    default: begin
                        scan = M_IDLE;
                        if (!ws) begin
                            if (b == ChSlash && !line_has_token) begin
                                add(EV_KEY, ChSlash, KIND_KEY);
                                add(EV_TEND, 8'h00, KIND_KEY);
                            end else if (b == ChDash) begin
                                scan = M_DASH;
                            end else if (b == ChQuote) begin
                                scan = M_QUOTE;
                            end else begin
                                add(EV_KEY, b, KIND_KEY);
                                scan = M_WORD;
                            end
                            line_has_token = 1'b1;
                        end
                    end
                endcase
            end
            if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
            awaited = {awaited, step_out};
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_word(logic [2:0] ev, logic [7:0] d, logic [1:0] k, logic last);
            tok_event_t e;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result word ev=%0d byte=%02h kind=%0d last=%0b",
                                 ev, d, k, last));
            end else begin
                e = awaited.pop_front();
                results_checked++;
                if (ev !== e.ev || d !== e.data || k !== e.kind || last !== e.last) begin
                    report($sformatf("got ev=%0d byte=%02h kind=%0d last=%0b, want %0d %02h %0d %0b",
                                     ev, d, k, last, e.ev, e.data, e.kind, e.last));
                end
            end
        endtask
    endclass

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_cmd;
    logic [7:0] s_text_byte;
    logic       m_valid;
    logic       m_ready;
    logic [2:0] m_event_res;
    logic [7:0] m_out_byte;
    logic [1:0] m_token_kind;
    logic       m_last_of_run;

    token_scoreboard sb = new;
    int send_idle_pct;
    int recv_stall_pct;
    int words_sent;
    int lines_sent;

    command_line_tokenizer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_text_byte  (s_text_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_res  (m_event_res),
        .m_out_byte   (m_out_byte),
        .m_token_kind (m_token_kind),
        .m_last_of_run(m_last_of_run)
    );

    always #4 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_word(m_event_res, m_out_byte, m_token_kind, m_last_of_run);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(cmd_t cmd, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_text_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(cmd, b);
        words_sent++;
        if (cmd == CMD_EOL) lines_sent++;
        @(negedge aclk);
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(CMD_BYTE, b);
    endtask

    task automatic send_eol();
        send_item(CMD_EOL, 8'($urandom_range(255)));
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
        send_eol();
    endtask

    function automatic logic [7:0] blank_byte();
        int r;
        r = $urandom_range(5);
        return (r < 5) ? 8'(9 + r) : ChSpace;
    endfunction

    function automatic logic [7:0] word_byte();
        int r;
        logic [7:0] b;
        r = $urandom_range(9);
        if (r < 6) return 8'("a" + $urandom_range(25));
        if (r == 9) begin
            case ($urandom_range(3))
                0: return ChSlash;
                1: return ChDash;
                2: return ChQuote;
                default: return ChBslash;
            endcase
        end
        do b = 8'($urandom_range(255)); while (token_scoreboard::blank(b));
        return b;
    endfunction

    task automatic send_quoted(bit closed);
        logic [7:0] b;
        send_byte(ChQuote);
        repeat ($urandom_range(4)) begin
            if ($urandom_range(2) == 0) begin
                send_byte(ChBslash);
                case ($urandom_range(4))
                    0: send_byte(ChN);
                    1: send_byte(ChT);
                    2: send_byte(ChBslash);
                    3: send_byte(ChQuote);
                    default: send_byte(8'($urandom_range(255)));
                endcase
            end else begin
                do b = 8'($urandom_range(255)); while (b == ChQuote || b == ChBslash);
                send_byte(b);
            end
        end
        if (closed) send_byte(ChQuote);
    endtask

    task automatic send_token_line();
        int n_tok;
        n_tok = $urandom_range(5);
        if ($urandom_range(3) == 0) send_byte(blank_byte());
        for (int t = 0; t < n_tok; t++) begin
            case ($urandom_range(9))
                0: send_byte(ChSlash);
                1, 2: begin
                    if ($urandom_range(3) == 0) send_byte(ChDash);
                    repeat ($urandom_range(1, 4)) send_byte(word_byte());
                end
                3, 4, 5: begin
                    send_byte(ChDash);
                    send_byte(ChDash);
                    repeat ($urandom_range(3)) send_byte(word_byte());
                    if ($urandom_range(9) < 7) begin
                        send_byte(blank_byte());
                        if ($urandom_range(1)) begin
                            send_quoted($urandom_range(7) != 0);
                        end else begin
                            if ($urandom_range(3) == 0) send_byte(ChDash);
                            repeat ($urandom_range(1, 3)) send_byte(word_byte());
                        end
                    end
                end
                6, 7: send_quoted($urandom_range(7) != 0);
                8: send_byte(ChDash);
                default: begin
                    // A closing quote followed at once by the next token.
                    send_quoted(1'b1);
                    send_byte(word_byte());
                end
            endcase
            if ($urandom_range(4) != 0) repeat ($urandom_range(1, 2)) send_byte(blank_byte());
        end
        send_eol();
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 10)) begin
            send_item(cmd_t'(($urandom_range(9) == 0) ? CMD_EOL : CMD_BYTE),
                      8'($urandom_range(255)));
        end
        if ($urandom_range(1)) send_eol();
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.awaited.size() != 0) @(negedge aclk);
    endtask

    initial begin
        int idle_mix[4];
        int stall_mix[4];
        int target;
        idle_mix       = '{0, 67, 0, 16};
        stall_mix      = '{0, 0, 67, 16};
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_cmd          = CMD_BYTE;
        s_text_byte    = 8'h00;
        m_ready        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        words_sent     = 0;
        lines_sent     = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Slash keyword, held dash becoming a keyword, slash later in the line.
        send_text("/-x /");
        // Flag with quoted argument: tab escape, escaped quote, lone backslash at line end.
        send_text("--f \"\\t\\\"\\");
        // Backslash and unknown escapes, closing quote, empty flag and dash argument.
        send_text("\"\\\\\\q\"-- -");

        for (int p = 0; p < 4; p++) begin
            drain();
            send_idle_pct  = idle_mix[p];
            recv_stall_pct = stall_mix[p];
            target = words_sent + 125;
            while (words_sent < target) begin
                if ($urandom_range(4) == 0) send_noise();
                else send_token_line();
            end
        end

        drain();
        repeat (16) @(negedge aclk);
        $display("Run covered %0d input words over %0d lines and checked %0d result words,",
                 words_sent, lines_sent, sb.results_checked);
        $display("with free flow, sender gaps, receiver stalls and both together.");
        if (sb.mismatches == 0) begin
            $display("tb_command_line_tokenizer: clean");
        end else begin
            $display("tb_command_line_tokenizer: errors");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Timed out with %0d result words still outstanding.", sb.awaited.size());
        $display("tb_command_line_tokenizer: errors");
        $finish;
    end

endmodule

FILE: command_line_tokenizer.f
design/clt_pkg.sv
design/clt_decode.sv
design/clt_emit.sv
design/command_line_tokenizer.sv
test/tb_command_line_tokenizer.sv
